>>> rtl/rbs_pkg.sv
// rbs_pkg: shared types and constants of the red-black sor heat solver
// grid geometry, codes, controller states and the controller/datapath bundles
// no dependencies
package rbs_pkg;

	localparam int MaxRows = 64;
	localparam int MaxCols = 64;
	localparam int RowW    = 6;
	localparam int ColW    = 6;
	localparam int AddrW   = RowW + ColW;
	localparam int Cells   = MaxRows * MaxCols;
	localparam int DimW    = 7;
	localparam int DivSteps = 66;
	localparam int OmegaFrac = 14;

	// item actions
	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_SOLVE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	// configuration register indexes
	localparam logic [2:0] CFG_ROWS  = 3'd0;
	localparam logic [2:0] CFG_COLS  = 3'd1;
	localparam logic [2:0] CFG_ITER  = 3'd2;
	localparam logic [2:0] CFG_OMEGA = 3'd3;
	localparam logic [2:0] CFG_TOL   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_OUT,
		ST_SWEEP,
		ST_ROW,
		ST_CELL,
		ST_DIV,
		ST_DIFF,
		ST_STEP,
		ST_NEW,
		ST_EDGE_RD,
		ST_EDGE_WR,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		EDGE_L,
		EDGE_R,
		EDGE_B,
		EDGE_T
	} edge_t;

	// controller to datapath commands
	typedef struct packed {
		logic [AddrW-1:0] t_addr;
		logic [AddrW-1:0] c_addr;
		logic [AddrW-1:0] w_addr;
		logic             sel_down;
		logic             ld_we;
		logic             old_ld;
		logic             acc_clr;
		logic             mac;
		logic             div_start;
		logic             diff_ld;
		logic             step_mul;
		logic             new_wr;
		logic             edge_wr;
		logic             maxc_clr;
		logic             out_rd;
		logic             out_solve;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic flag_rd;
		logic div_done;
		logic below_tol;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/rbs_datapath.sv
// rbs_datapath: cell stores, shared multiplier, bit-serial divider, update
// arithmetic and the result word register
// depends on rbs_pkg
module rbs_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rbs_pkg::cmd_t          cmd,
	output rbs_pkg::sts_t          sts,
	input  logic [5:0]             cell_row,
	input  logic [5:0]             cell_col,
	input  logic signed [31:0]     temperature,
	input  logic [31:0]            cond_right,
	input  logic [31:0]            cond_down,
	input  logic                   is_fixed,
	input  logic signed [31:0]     fixed_temperature,
	input  logic [14:0]            relax_factor,
	input  logic [30:0]            tolerance,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [31:0]     read_temperature,
	output logic [30:0]            max_change
);

	// cell stores
	logic signed [31:0] temp_mem [rbs_pkg::Cells];
	logic [31:0]        cr_mem   [rbs_pkg::Cells];
	logic [31:0]        cd_mem   [rbs_pkg::Cells];
	logic               flag_mem [rbs_pkg::Cells];
	logic signed [31:0] fval_mem [rbs_pkg::Cells];

	logic signed [31:0] t_rd_q, fval_rd_q;
	logic [31:0]        cr_rd_q, cd_rd_q;
	logic               flag_rd_q;

	logic [rbs_pkg::AddrW-1:0] ld_addr, tw_addr;
	logic                      tw_en;
	logic signed [31:0]        tw_data, nv;

	assign ld_addr = {cell_row, cell_col};

	// temperature write port: loads, cell updates and edge handling
	always_comb begin
		tw_en   = cmd.ld_we | cmd.new_wr | cmd.edge_wr;
		tw_addr = cmd.ld_we ? ld_addr : cmd.w_addr;
		if (cmd.ld_we) begin
			tw_data = temperature;
		end else if (cmd.new_wr) begin
			tw_data = nv;
		end else begin
			tw_data = flag_rd_q ? fval_rd_q : t_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tw_en) begin
			temp_mem[tw_addr] <= tw_data;
		end
		t_rd_q <= temp_mem[cmd.t_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_we) begin
			cr_mem[ld_addr]   <= cond_right;
			cd_mem[ld_addr]   <= cond_down;
			flag_mem[ld_addr] <= is_fixed;
			fval_mem[ld_addr] <= fixed_temperature;
		end
		cr_rd_q   <= cr_mem[cmd.c_addr];
		cd_rd_q   <= cd_mem[cmd.c_addr];
		flag_rd_q <= flag_mem[cmd.c_addr];
		fval_rd_q <= fval_mem[cmd.c_addr];
	end

	// shared multiplier: conductance times temperature, or |diff| times omega
	logic [31:0]        g_sel, g_s1, diff_mag;
	logic signed [32:0] mul_a, mul_b, diff_q, diff_abs;
	logic signed [65:0] prod_s1;
	logic               mac_s1;

	assign g_sel    = cmd.sel_down ? cd_rd_q : cr_rd_q;
	assign diff_abs = diff_q[32] ? -diff_q : diff_q;
	assign diff_mag = diff_abs[31:0];

	always_comb begin
		if (cmd.step_mul) begin
			mul_a = $signed({1'b0, diff_mag});
			mul_b = $signed({18'd0, relax_factor});
		end else begin
			mul_a = $signed({1'b0, g_sel});
			mul_b = $signed({t_rd_q[31], t_rd_q});
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		g_s1    <= g_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
		end else begin
			mac_s1 <= cmd.mac;
		end
	end

	// weighted sum and conductance sum
	logic signed [66:0] acc_q;
	logic [33:0]        den_q;
	logic signed [31:0] old_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
			den_q <= '0;
		end else if (mac_s1) begin
			acc_q <= acc_q + {prod_s1[65], prod_s1};
			den_q <= den_q + {2'd0, g_s1};
		end
		if (cmd.old_ld) begin
			old_q <= t_rd_q;
		end
	end

	// restoring divider, one quotient bit a cycle
	logic [65:0]        dq_q;
	logic [33:0]        rem_q;
	logic [6:0]         div_cnt_q;
	logic               div_busy_q, neg_q;
	logic signed [66:0] acc_abs;
	logic [34:0]        rem_sh;

	assign acc_abs = acc_q[66] ? -acc_q : acc_q;
	assign rem_sh  = {rem_q, dq_q[65]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q  <= acc_abs[65:0];
			rem_q <= '0;
			neg_q <= acc_q[66];
		end else if (div_busy_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= 34'(rem_sh - {1'b0, den_q});
				dq_q  <= {dq_q[64:0], 1'b1};
			end else begin
				rem_q <= rem_sh[33:0];
				dq_q  <= {dq_q[64:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= 7'(rbs_pkg::DivSteps);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 7'd1;
			if (div_cnt_q == 7'd1) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	// quotient to saturated mean
	logic               q_big, q_gt_min, q_ge_max;
	logic [31:0]        q_neg;
	logic signed [31:0] gauss;

	always_comb begin
		q_big    = |dq_q[65:32];
		q_gt_min = q_big || (dq_q[31:0] > 32'h8000_0000);
		q_ge_max = q_big || dq_q[31];
		q_neg    = q_gt_min ? 32'h8000_0000 : dq_q[31:0];
		if (den_q == '0) begin
			gauss = '0;
		end else if (neg_q) begin
			gauss = $signed(-q_neg);
		end else begin
			gauss = q_ge_max ? 32'sh7FFF_FFFF : $signed(dq_q[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff_ld) begin
			diff_q <= 33'({gauss[31], gauss}) - 33'({old_q[31], old_q});
		end
	end

	// relaxed value and its change
	logic [33:0]        step;
	logic signed [34:0] old_x, nv_x, ch_x;
	logic [32:0]        change;

	always_comb begin
		step  = prod_s1[47:14];
		old_x = 35'(old_q);
		if (diff_q[32]) begin
			nv_x = old_x - $signed({1'b0, step});
		end else begin
			nv_x = old_x + $signed({1'b0, step});
		end
		if (nv_x > 35'sh0_7FFF_FFFF) begin
			nv = 32'sh7FFF_FFFF;
		end else if (nv_x < -35'sh0_8000_0000) begin
			nv = 32'sh8000_0000;
		end else begin
			nv = nv_x[31:0];
		end
		ch_x   = 35'(nv) - old_x;
		change = ch_x[34] ? 33'(-ch_x) : ch_x[32:0];
	end

	// largest change of the sweep
	logic [32:0] maxc_q;

	always_ff @(posedge clk) begin
		if (cmd.maxc_clr) begin
			maxc_q <= '0;
		end else if (cmd.new_wr && change > maxc_q) begin
			maxc_q <= change;
		end
	end

	// result word register
	logic               out_valid_q;
	logic signed [31:0] rd_temp_q;
	logic [30:0]        maxch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_rd || cmd.out_solve) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_rd) begin
			rd_temp_q <= t_rd_q;
			maxch_q   <= '0;
		end else if (cmd.out_solve) begin
			rd_temp_q <= '0;
			maxch_q   <= (|maxc_q[32:31]) ? 31'h7FFF_FFFF : maxc_q[30:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign read_temperature = rd_temp_q;
	assign max_change       = maxch_q;

	assign sts.flag_rd   = flag_rd_q;
	assign sts.div_done  = !div_busy_q;
	assign sts.below_tol = maxc_q < {2'd0, tolerance};
	assign sts.out_free  = !out_valid_q || out_ready;

	// checks
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy_q)
		else $error("divider restarted while busy");
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_we |-> !(cmd.new_wr || cmd.edge_wr))
		else $error("load collides with solver write");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_rd || cmd.out_solve) |-> (!out_valid_q || out_ready))
		else $error("result word overwritten");

endmodule

>>> rtl/rbs_ctrl.sv
// rbs_ctrl: sequencer of the solver, walks items, sweeps, cells and edges
// drives rbs_datapath through the command bundle
// depends on rbs_pkg
module rbs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      action,
	input  logic [5:0]      cell_row,
	input  logic [5:0]      cell_col,
	input  logic [6:0]      grid_rows,
	input  logic [6:0]      grid_cols,
	input  logic [15:0]     max_iterations,
	input  rbs_pkg::sts_t   sts,
	output rbs_pkg::cmd_t   cmd
);

	rbs_pkg::state_t state_q, state_d;
	rbs_pkg::edge_t  phase_q, phase_d;
	logic [15:0] it_q, it_d;
	logic        color_q, color_d;
	logic [6:0]  r_q, r_d, c_q, c_d, k_q, k_d;
	logic [2:0]  step_q, step_d;
	logic [rbs_pkg::AddrW-1:0] rd_addr_q, rd_addr_d;

	// clamped grid size
	logic [6:0] rows, cols;

	always_comb begin
		if (grid_rows < 7'd3) begin
			rows = 7'd3;
		end else if (grid_rows > 7'(rbs_pkg::MaxRows)) begin
			rows = 7'(rbs_pkg::MaxRows);
		end else begin
			rows = grid_rows;
		end
		if (grid_cols < 7'd3) begin
			cols = 7'd3;
		end else if (grid_cols > 7'(rbs_pkg::MaxCols)) begin
			cols = 7'(rbs_pkg::MaxCols);
		end else begin
			cols = grid_cols;
		end
	end

	// cell and neighbor addresses
	logic [6:0] rm1, rp1, cm1, cp1, cp2, c0, lim;
	logic [rbs_pkg::AddrW-1:0] idx, e_idx, e_from;
	logic [6:0] rows_m1, rows_m2, cols_m1, cols_m2;

	assign rm1 = r_q - 7'd1;
	assign rp1 = r_q + 7'd1;
	assign cm1 = c_q - 7'd1;
	assign cp1 = c_q + 7'd1;
	assign cp2 = c_q + 7'd2;
	assign c0  = ((~r_q[0]) == color_q) ? 7'd1 : 7'd2;
	assign idx = {r_q[5:0], c_q[5:0]};
	assign rows_m1 = rows - 7'd1;
	assign rows_m2 = rows - 7'd2;
	assign cols_m1 = cols - 7'd1;
	assign cols_m2 = cols - 7'd2;

	// edge cell and its inner neighbor
	always_comb begin
		unique case (phase_q)
			rbs_pkg::EDGE_L: begin
				e_idx  = {k_q[5:0], 6'd0};
				e_from = {k_q[5:0], 6'd1};
			end
			rbs_pkg::EDGE_R: begin
				e_idx  = {k_q[5:0], cols_m1[5:0]};
				e_from = {k_q[5:0], cols_m2[5:0]};
			end
			rbs_pkg::EDGE_B: begin
				e_idx  = {6'd0, k_q[5:0]};
				e_from = {6'd1, k_q[5:0]};
			end
			default: begin
				e_idx  = {rows_m1[5:0], k_q[5:0]};
				e_from = {rows_m2[5:0], k_q[5:0]};
			end
		endcase
		lim = (phase_q == rbs_pkg::EDGE_L || phase_q == rbs_pkg::EDGE_R) ? rows : cols;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rbs_pkg::ST_IDLE;
			phase_q   <= rbs_pkg::EDGE_L;
			it_q      <= '0;
			color_q   <= 1'b0;
			r_q       <= '0;
			c_q       <= '0;
			k_q       <= '0;
			step_q    <= '0;
			rd_addr_q <= '0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			it_q      <= it_d;
			color_q   <= color_d;
			r_q       <= r_d;
			c_q       <= c_d;
			k_q       <= k_d;
			step_q    <= step_d;
			rd_addr_q <= rd_addr_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		it_d      = it_q;
		color_d   = color_q;
		r_d       = r_q;
		c_d       = c_q;
		k_d       = k_q;
		step_d    = step_q;
		rd_addr_d = rd_addr_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.t_addr = idx;
		cmd.c_addr = idx;
		cmd.w_addr = idx;

		unique case (state_q)
			rbs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action)
						rbs_pkg::ACT_LOAD: begin
							cmd.ld_we = 1'b1;
						end
						rbs_pkg::ACT_SOLVE: begin
							cmd.maxc_clr = 1'b1;
							it_d = '0;
							state_d = (max_iterations == '0) ? rbs_pkg::ST_DONE
								: rbs_pkg::ST_SWEEP;
						end
						rbs_pkg::ACT_READ: begin
							rd_addr_d = {cell_row, cell_col};
							state_d   = rbs_pkg::ST_RD_ADDR;
						end
						default: ;
					endcase
				end
			end
			rbs_pkg::ST_RD_ADDR: begin
				cmd.t_addr = rd_addr_q;
				state_d = rbs_pkg::ST_RD_OUT;
			end
			rbs_pkg::ST_RD_OUT: begin
				cmd.t_addr = rd_addr_q;
				if (sts.out_free) begin
					cmd.out_rd = 1'b1;
					state_d = rbs_pkg::ST_IDLE;
				end
			end
			rbs_pkg::ST_SWEEP: begin
				cmd.maxc_clr = 1'b1;
				color_d = 1'b0;
				r_d     = 7'd1;
				state_d = rbs_pkg::ST_ROW;
			end
			rbs_pkg::ST_ROW: begin
				if (rp1 < rows) begin
					c_d = c0;
					if (c0 + 7'd1 < cols) begin
						step_d  = '0;
						state_d = rbs_pkg::ST_CELL;
					end else begin
						r_d = rp1;
					end
				end else if (!color_q) begin
					color_d = 1'b1;
					r_d     = 7'd1;
				end else begin
					phase_d = rbs_pkg::EDGE_L;
					k_d     = '0;
					state_d = rbs_pkg::ST_EDGE_RD;
				end
			end
			rbs_pkg::ST_CELL: begin
				step_d = step_q + 3'd1;
				case (step_q)
					3'd0: ;
					3'd1: begin
						cmd.old_ld  = 1'b1;
						cmd.acc_clr = 1'b1;
						cmd.t_addr  = {rm1[5:0], c_q[5:0]};
						cmd.c_addr  = {rm1[5:0], c_q[5:0]};
						// fixed inner cells are left alone
						if (sts.flag_rd) begin
							if (cp2 + 7'd1 < cols) begin
								c_d    = cp2;
								step_d = '0;
							end else begin
								r_d     = rp1;
								state_d = rbs_pkg::ST_ROW;
							end
						end
					end
					3'd2: begin
						cmd.mac      = 1'b1;
						cmd.sel_down = 1'b1;
						cmd.t_addr   = {rp1[5:0], c_q[5:0]};
					end
					3'd3: begin
						cmd.mac      = 1'b1;
						cmd.sel_down = 1'b1;
						cmd.t_addr   = {r_q[5:0], cm1[5:0]};
						cmd.c_addr   = {r_q[5:0], cm1[5:0]};
					end
					3'd4: begin
						cmd.mac    = 1'b1;
						cmd.t_addr = {r_q[5:0], cp1[5:0]};
					end
					3'd5: begin
						cmd.mac = 1'b1;
					end
					3'd6: ;
					default: begin
						cmd.div_start = 1'b1;
						state_d = rbs_pkg::ST_DIV;
					end
				endcase
			end
			rbs_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_d = rbs_pkg::ST_DIFF;
				end
			end
			rbs_pkg::ST_DIFF: begin
				cmd.diff_ld = 1'b1;
				state_d = rbs_pkg::ST_STEP;
			end
			rbs_pkg::ST_STEP: begin
				cmd.step_mul = 1'b1;
				state_d = rbs_pkg::ST_NEW;
			end
			rbs_pkg::ST_NEW: begin
				cmd.new_wr = 1'b1;
				if (cp2 + 7'd1 < cols) begin
					c_d     = cp2;
					step_d  = '0;
					state_d = rbs_pkg::ST_CELL;
				end else begin
					r_d     = rp1;
					state_d = rbs_pkg::ST_ROW;
				end
			end
			rbs_pkg::ST_EDGE_RD: begin
				cmd.t_addr = e_from;
				cmd.c_addr = e_idx;
				state_d = rbs_pkg::ST_EDGE_WR;
			end
			rbs_pkg::ST_EDGE_WR: begin
				cmd.t_addr  = e_from;
				cmd.c_addr  = e_idx;
				cmd.w_addr  = e_idx;
				cmd.edge_wr = 1'b1;
				state_d = rbs_pkg::ST_EDGE_RD;
				if (k_q + 7'd1 < lim) begin
					k_d = k_q + 7'd1;
				end else begin
					k_d = '0;
					unique case (phase_q)
						rbs_pkg::EDGE_L: phase_d = rbs_pkg::EDGE_R;
						rbs_pkg::EDGE_R: phase_d = rbs_pkg::EDGE_B;
						rbs_pkg::EDGE_B: phase_d = rbs_pkg::EDGE_T;
						default: state_d = rbs_pkg::ST_CHECK;
					endcase
				end
			end
			rbs_pkg::ST_CHECK: begin
				if (sts.below_tol || it_q == max_iterations - 16'd1) begin
					state_d = rbs_pkg::ST_DONE;
				end else begin
					it_d    = it_q + 16'd1;
					state_d = rbs_pkg::ST_SWEEP;
				end
			end
			rbs_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_solve = 1'b1;
					state_d = rbs_pkg::ST_IDLE;
				end
			end
			default: state_d = rbs_pkg::ST_IDLE;
		endcase
	end

	// checks
	a_cell_inner: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbs_pkg::ST_CELL) |-> (r_q >= 7'd1 && rp1 < rows && c_q >= 7'd1 && cp1 < cols))
		else $error("relaxing a cell off the inner grid");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == rbs_pkg::ST_DIV && !sts.div_done))
		else $error("divider did not start");
	a_edge_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbs_pkg::ST_EDGE_WR) |-> (k_q < lim))
		else $error("edge index past the grid");

endmodule

>>> rtl/red_black_sor_conductance_heat.sv
// red_black_sor_conductance_heat: top level, configuration registers and
// the controller and datapath instances
// depends on rbs_pkg, rbs_ctrl, rbs_datapath
//
// Load words write one cell each and are taken back to back. A read word
// holds intake through ST_RD_ADDR and ST_RD_OUT, and its result is registered
// once the output register is free. A solve word runs up to max_iterations
// red-black sweeps; each relaxed inner cell reads the stores and accumulates
// on the single read port of each cell store, runs the bit-serial 66-step
// divider of the weighted mean, and then forms and writes the new value. A
// fixed inner cell is skipped once its flag is read, each edge cell is
// rewritten in a read and a write state every sweep, and each sweep passes
// through ST_ROW for each row and color. Intake stalls for the whole solve.
// A finished result waits in an output register while the next word is taken; an unwritten cell read is undefined.
module red_black_sor_conductance_heat (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [5:0]         cell_row,
	input  logic [5:0]         cell_col,
	input  logic signed [31:0] temperature,
	input  logic [31:0]        cond_right,
	input  logic [31:0]        cond_down,
	input  logic               is_fixed,
	input  logic signed [31:0] fixed_temperature,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] read_temperature,
	output logic [30:0]        max_change,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	logic [6:0]  grid_rows_q, grid_cols_q;
	logic [15:0] max_iter_q;
	logic [14:0] omega_q;
	logic [30:0] tol_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= 7'd64;
			grid_cols_q <= 7'd64;
			max_iter_q  <= 16'd100;
			omega_q     <= 15'd16384;
			tol_q       <= 31'd66;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbs_pkg::CFG_ROWS:  grid_rows_q <= cfg_data[6:0];
				rbs_pkg::CFG_COLS:  grid_cols_q <= cfg_data[6:0];
				rbs_pkg::CFG_ITER:  max_iter_q  <= cfg_data[15:0];
				rbs_pkg::CFG_OMEGA: omega_q     <= cfg_data[14:0];
				rbs_pkg::CFG_TOL:   tol_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	rbs_pkg::cmd_t cmd;
	rbs_pkg::sts_t sts;

	rbs_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.cell_row       (cell_row),
		.cell_col       (cell_col),
		.grid_rows      (grid_rows_q),
		.grid_cols      (grid_cols_q),
		.max_iterations (max_iter_q),
		.sts            (sts),
		.cmd            (cmd)
	);

	rbs_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cell_row          (cell_row),
		.cell_col          (cell_col),
		.temperature       (temperature),
		.cond_right        (cond_right),
		.cond_down         (cond_down),
		.is_fixed          (is_fixed),
		.fixed_temperature (fixed_temperature),
		.relax_factor      (omega_q),
		.tolerance         (tol_q),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.read_temperature  (read_temperature),
		.max_change        (max_change)
	);

endmodule
